>>> hdl/kvt_pkg.sv
package kvt_pkg;

   // store geometry
   localparam int DEPTH   = 256;
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_W = $clog2(DEPTH + 1);

   // field widths
   localparam int OP_W    = 3;
   localparam int KEY_W   = 32;
   localparam int VALUE_W = 64;
   localparam int POS_W   = 8;
   localparam int CAP_W   = 9;
   localparam int ENTRY_W = 9;

   // compare widths for count against capacity and position
   localparam int CMP_W  = (COUNT_W > CAP_W) ? COUNT_W : CAP_W;
   localparam int PCMP_W = (COUNT_W > POS_W) ? COUNT_W : POS_W;

   localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

   // match encoder split into groups
   localparam int GROUP_W    = (ADDR_W + 1) / 2;
   localparam int GROUP_SIZE = 1 << GROUP_W;
   localparam int GROUPS     = (DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int MATCH_W    = GROUPS * GROUP_SIZE;

   // operation codes
   localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
   localparam logic [OP_W-1:0] OP_UPDATE = 3'd1;
   localparam logic [OP_W-1:0] OP_UPSERT = 3'd2;
   localparam logic [OP_W-1:0] OP_ERASE  = 3'd3;
   localparam logic [OP_W-1:0] OP_LOOKUP = 3'd4;
   localparam logic [OP_W-1:0] OP_READ   = 3'd5;

   // control broadcast to the cell row
   typedef struct packed {
      logic              shift_up;
      logic              shift_down;
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [KEY_W-1:0]  wr_key;
   } kvt_cell_ctl_type;

   // encoded search result
   typedef struct packed {
      logic              hit;
      logic [ADDR_W-1:0] at;
   } kvt_hit_type;

endpackage

>>> hdl/bounded_key_value_table_unit.sv
// channel  direction  handshake            word
// req      in         req_valid/req_stall  operation, key, value, position
// rsp      out        rsp_valid/rsp_stall  ok, found_key, found_value, entry_count, is_empty
// csr      in         csr_valid/csr_ready  capacity
//
// an item passes from one acceptance to the next through the accepting idle
// state, key compare in the cell row, two encoder stages, the execute step with
// memory write or read, and the result register load, which makes the result word valid.
// the two-stage match encoder and the registered memory read set the length of that path.
// synchronous reset empties the table and sets capacity to 256.
// a new word is taken while a result still waits; a stalled result only holds
// the block in its last step until the output register is free.
module bounded_key_value_table_unit import kvt_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [OP_W-1:0]    req_operation,
   input  logic [KEY_W-1:0]   req_key,
   input  logic [VALUE_W-1:0] req_value,
   input  logic [POS_W-1:0]   req_position,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_ok,
   output logic [KEY_W-1:0]   rsp_found_key,
   output logic [VALUE_W-1:0] rsp_found_value,
   output logic [ENTRY_W-1:0] rsp_entry_count,
   output logic               rsp_is_empty,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [CAP_W-1:0]   csr_capacity
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MATCH = 3'd1;
   localparam logic [2:0] ST_ENC1  = 3'd2;
   localparam logic [2:0] ST_ENC2  = 3'd3;
   localparam logic [2:0] ST_EXEC  = 3'd4;
   localparam logic [2:0] ST_RESP  = 3'd5;

   logic [2:0]         state_ff, state_in;
   logic [CAP_W-1:0]   cap_ff;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               ok_ff, ok_in;
   logic [OP_W-1:0]    op_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [VALUE_W-1:0] value_ff;
   logic [POS_W-1:0]   pos_ff;

   logic [KEY_W-1:0]   key_mem_ff [DEPTH];
   logic [VALUE_W-1:0] val_mem_ff [DEPTH];
   logic [KEY_W-1:0]   rd_key_ff;
   logic [VALUE_W-1:0] rd_val_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_ok_ff;
   logic [KEY_W-1:0]   rsp_key_ff;
   logic [VALUE_W-1:0] rsp_val_ff;
   logic [ENTRY_W-1:0] rsp_count_ff;
   logic               rsp_empty_ff;

   logic               accept;
   logic               load_rsp;
   logic [DEPTH-1:0]   match_vec;
   kvt_hit_type        hit;
   kvt_cell_ctl_type   cell_ctl;

   logic               key_we, val_we;
   logic [ADDR_W-1:0]  wr_addr;
   logic [KEY_W-1:0]   wr_key;
   logic [VALUE_W-1:0] wr_val;
   logic               rd_en;
   logic [ADDR_W-1:0]  rd_addr;

   logic [ADDR_W-1:0]  last_addr, cnt_addr;
   logic [CMP_W-1:0]   eff_cap;
   logic               room, pos_ok;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign load_rsp  = (state_ff == ST_RESP) && (!rsp_valid_ff || !rsp_stall);
   assign csr_ready = 1'b1;

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_MATCH;
         ST_MATCH: state_in = ST_ENC1;
         ST_ENC1:  state_in = ST_ENC2;
         ST_ENC2:  state_in = ST_EXEC;
         ST_EXEC:  state_in = ST_RESP;
         ST_RESP:  if (load_rsp) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // capacity limits and position range
   assign last_addr = ADDR_W'(count_ff - COUNT_W'(1));
   assign cnt_addr  = ADDR_W'(count_ff);
   assign eff_cap   = (CMP_W'(cap_ff) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(cap_ff);
   assign room      = (CMP_W'(count_ff) < eff_cap) && (count_ff < COUNT_W'(DEPTH));
   assign pos_ok    = PCMP_W'(pos_ff) < PCMP_W'(count_ff);

   // execute step: store writes, cell updates and reads; the match step fetches the last pair
   always_comb begin
      key_we   = 1'b0;
      val_we   = 1'b0;
      wr_addr  = hit.at;
      wr_key   = key_ff;
      wr_val   = value_ff;
      rd_en    = 1'b0;
      rd_addr  = last_addr;
      cell_ctl = '0;
      cell_ctl.wr_addr = hit.at;
      cell_ctl.wr_key  = key_ff;
      count_in = count_ff;
      ok_in    = ok_ff;
      if (state_ff == ST_MATCH) begin
         // fetch the last pair for a possible erase
         rd_en = 1'b1;
      end else if (state_ff == ST_EXEC) begin
         ok_in = 1'b0;
         case (op_ff) inside
            OP_INSERT, OP_UPSERT: begin
               if (hit.hit) begin
                  if (op_ff == OP_UPSERT) begin
                     val_we = 1'b1;
                     ok_in  = 1'b1;
                  end
               end else if (room) begin
                  key_we            = 1'b1;
                  val_we            = 1'b1;
                  wr_addr           = cnt_addr;
                  cell_ctl.wr_en    = 1'b1;
                  cell_ctl.wr_addr  = cnt_addr;
                  cell_ctl.shift_up = 1'b1;
                  count_in          = count_ff + COUNT_W'(1);
                  ok_in             = 1'b1;
               end
            end
            OP_UPDATE: begin
               if (hit.hit) begin
                  val_we = 1'b1;
                  ok_in  = 1'b1;
               end
            end
            OP_ERASE: begin
               // last pair fills the hole
               if (hit.hit) begin
                  key_we              = 1'b1;
                  val_we              = 1'b1;
                  wr_key              = rd_key_ff;
                  wr_val              = rd_val_ff;
                  cell_ctl.wr_en      = 1'b1;
                  cell_ctl.wr_key     = rd_key_ff;
                  cell_ctl.shift_down = 1'b1;
                  count_in            = count_ff - COUNT_W'(1);
                  ok_in               = 1'b1;
               end
            end
            OP_LOOKUP: begin
               if (hit.hit) begin
                  rd_en   = 1'b1;
                  rd_addr = hit.at;
                  ok_in   = 1'b1;
               end
            end
            OP_READ: begin
               if (pos_ok) begin
                  rd_en   = 1'b1;
                  rd_addr = ADDR_W'(pos_ff);
                  ok_in   = 1'b1;
               end
            end
            default: ok_in = 1'b0;
         endcase
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_ff       <= CAP_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            cap_ff <= csr_capacity;
         end
      end
   end

   // request word and per-item flags
   always_ff @(posedge clock) begin
      ok_ff <= ok_in;
      if (accept) begin
         op_ff    <= req_operation;
         key_ff   <= req_key;
         value_ff <= req_value;
         pos_ff   <= req_position;
      end
   end

   // key and value memories
   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem_ff[wr_addr] <= wr_key;
      end
      if (val_we) begin
         val_mem_ff[wr_addr] <= wr_val;
      end
      if (rd_en) begin
         rd_key_ff <= key_mem_ff[rd_addr];
         rd_val_ff <= val_mem_ff[rd_addr];
      end
   end

   // output word
   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_ok_ff    <= ok_ff;
         rsp_key_ff   <= (ok_ff && op_ff == OP_READ) ? rd_key_ff : '0;
         rsp_val_ff   <= (ok_ff && (op_ff == OP_READ || op_ff == OP_LOOKUP)) ?
                         rd_val_ff : '0;
         rsp_count_ff <= ENTRY_W'(count_ff);
         rsp_empty_ff <= (count_ff == '0);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ok          = rsp_ok_ff;
   assign rsp_found_key   = rsp_key_ff;
   assign rsp_found_value = rsp_val_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_is_empty    = rsp_empty_ff;

   // key compare row
   kvt_cell_row u_row (
      .clock      (clock),
      .reset      (reset),
      .ctl        (cell_ctl),
      .search_key (key_ff),
      .match      (match_vec)
   );

   // match position encoder
   kvt_match_enc u_enc (
      .clock (clock),
      .match (match_vec),
      .hit   (hit)
   );

   a_rsp_from_last_step: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RESP))
      else $error("result word raised outside the final step");

   a_count_only_exec: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_EXEC) |=> $stable(count_ff))
      else $error("entry count changed outside the execute step");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC) |=> (count_ff == $past(count_ff)) ||
         (count_ff == COUNT_W'($past(count_ff) + COUNT_W'(1))) ||
         (count_ff == COUNT_W'($past(count_ff) - COUNT_W'(1))))
      else $error("entry count moved by more than one");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(DEPTH))
      else $error("entry count beyond store depth");

endmodule

>>> hdl/kvt_cell.sv
module kvt_cell import kvt_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  kvt_cell_ctl_type ctl,
   input  logic             sel,
   input  logic [KEY_W-1:0] search_key,
   input  logic             below_active,
   input  logic             above_active,
   output logic             active,
   output logic             match
);

   logic             active_ff, active_in;
   logic             match_ff, match_in;
   logic [KEY_W-1:0] key_ff;

   // occupancy is a thermometer: insert pulls from below, erase from above
   always_comb begin
      active_in = active_ff;
      if (ctl.shift_up) begin
         active_in = below_active;
      end else if (ctl.shift_down) begin
         active_in = above_active;
      end
   end

   // local key compare
   assign match_in = active_ff && (key_ff == search_key);

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         match_ff  <= 1'b0;
      end else begin
         active_ff <= active_in;
         match_ff  <= match_in;
      end
   end

   // key storage
   always_ff @(posedge clock) begin
      if (ctl.wr_en && sel) begin
         key_ff <= ctl.wr_key;
      end
   end

   assign active = active_ff;
   assign match  = match_ff;

endmodule

>>> hdl/kvt_cell_row.sv
module kvt_cell_row import kvt_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  kvt_cell_ctl_type ctl,
   input  logic [KEY_W-1:0] search_key,
   output logic [DEPTH-1:0] match
);

   logic [DEPTH-1:0] active_vec;
   logic [DEPTH-1:0] sel_vec;

   // one cell per table position, occupancy handed between neighbors
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic below, above;

      if (i == 0) begin : g_first
         assign below = 1'b1;
      end else begin : g_mid_lo
         assign below = active_vec[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign above = 1'b0;
      end else begin : g_mid_hi
         assign above = active_vec[i+1];
      end

      assign sel_vec[i] = (ctl.wr_addr == ADDR_W'(i));

      kvt_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctl          (ctl),
         .sel          (sel_vec[i]),
         .search_key   (search_key),
         .below_active (below),
         .above_active (above),
         .active       (active_vec[i]),
         .match        (match[i])
      );
   end

   // keys held are unique, so at most one cell matches
   a_match_unique: assert property (@(posedge clock) disable iff (reset)
      $onehot0(match))
      else $error("more than one cell matched the search key");

endmodule

>>> hdl/kvt_match_enc.sv
module kvt_match_enc import kvt_pkg::*; (
   input  logic             clock,
   input  logic [DEPTH-1:0] match,
   output kvt_hit_type      hit
);

   logic [MATCH_W-1:0] match_pad;
   logic [GROUPS-1:0]  grp_any_ff, grp_any_in;
   logic [GROUP_W-1:0] grp_idx_ff [GROUPS];
   logic [GROUP_W-1:0] grp_idx_in [GROUPS];
   kvt_hit_type        hit_ff, hit_in;

   assign match_pad = MATCH_W'(match);

   // first stage: encode within each group
   always_comb begin
      for (int g = 0; g < GROUPS; g++) begin
         grp_any_in[g] = 1'b0;
         grp_idx_in[g] = '0;
         for (int b = 0; b < GROUP_SIZE; b++) begin
            if (match_pad[g*GROUP_SIZE + b]) begin
               grp_any_in[g] = 1'b1;
               grp_idx_in[g] = grp_idx_in[g] | GROUP_W'(b);
            end
         end
      end
   end

   // second stage: merge the groups
   always_comb begin
      hit_in.hit = |grp_any_ff;
      hit_in.at  = '0;
      for (int g = 0; g < GROUPS; g++) begin
         if (grp_any_ff[g]) begin
            hit_in.at = hit_in.at | ADDR_W'(g * GROUP_SIZE) | ADDR_W'(grp_idx_ff[g]);
         end
      end
   end

   always_ff @(posedge clock) begin
      grp_any_ff <= grp_any_in;
      grp_idx_ff <= grp_idx_in;
      hit_ff     <= hit_in;
   end

   assign hit = hit_ff;

endmodule
